[sv/abp_pkg.sv]
// Shared constants, operation-class codes and the divider control word for the prolongation block.
package abp_pkg;

  localparam int VALUE_WIDTH_DEF   = 32;
  localparam int SPACING_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    OP_COPY    = 2'd0,
    OP_RADIAL  = 2'd1,
    OP_ANGULAR = 2'd2,
    OP_CELL    = 2'd3
  } op_t;

  // Control that travels alongside each word through the divider chain.
  typedef struct packed {
    logic valid;
    logic neg;
    logic den_zero;
  } ctl_t;

endpackage

[sv/anisotropic_bilinear_prolongation.sv]
// Top level of the anisotropic bilinear prolongation block: front pipeline, divider chain, output.
//
//   channel   direction  handshake           payload
//   input     in         start / busy        op, rad_gap_lo, rad_gap_hi, ang_gap_lo,
//                                            ang_gap_hi, val_lo_lo, val_hi_lo,
//                                            val_lo_hi, val_hi_hi
//   result    out        done (one cycle)    fine_value
//
// A word is taken at every edge where start is high; busy is never raised, so one
// word per clock is sustained with no gaps.
// Each result passes through five front stages, one divider cell per quotient bit,
// and the output register. The length of the divider chain follows VALUE_WIDTH.
// Reset is synchronous and clears every valid flag in the pipeline; words in flight are
// dropped. The receiver cannot stall, so nothing holds and done is a single-cycle strobe.
module anisotropic_bilinear_prolongation import abp_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int SPACING_WIDTH = SPACING_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op,
  input  logic [SPACING_WIDTH-1:0]      rad_gap_lo,
  input  logic [SPACING_WIDTH-1:0]      rad_gap_hi,
  input  logic [SPACING_WIDTH-1:0]      ang_gap_lo,
  input  logic [SPACING_WIDTH-1:0]      ang_gap_hi,
  input  logic signed [VALUE_WIDTH-1:0] val_lo_lo,
  input  logic signed [VALUE_WIDTH-1:0] val_hi_lo,
  input  logic signed [VALUE_WIDTH-1:0] val_lo_hi,
  input  logic signed [VALUE_WIDTH-1:0] val_hi_hi,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] fine_value
);

  localparam int VW  = VALUE_WIDTH;
  localparam int DW  = 2 * SPACING_WIDTH + 2;
  localparam int LAT = VW + 6;

  // Signals between neighbouring cells; index 0 is the front pipeline's output.
  ctl_t          ctl_c [VW+1];
  logic [DW-1:0] rem_c [VW+1];
  logic [VW-1:0] num_c [VW+1];
  logic [VW-1:0] quo_c [VW+1];
  logic [DW-1:0] den_c [VW+1];

  logic [VW-1:0] result_next;

  // The pipeline never refuses a word.
  assign busy = 1'b0;

  // The front pipeline forms the signed weighted sum of the four corners and the product
  // of the spacing sums, then splits the sum into sign and magnitude. The copy class is
  // folded in as a unit weight on the lower corner over a unit denominator.
  abp_front #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .SPACING_WIDTH (SPACING_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .op         (op),
    .rad_gap_lo (rad_gap_lo),
    .rad_gap_hi (rad_gap_hi),
    .ang_gap_lo (ang_gap_lo),
    .ang_gap_hi (ang_gap_hi),
    .val_lo_lo  (val_lo_lo),
    .val_hi_lo  (val_hi_lo),
    .val_lo_hi  (val_lo_hi),
    .val_hi_hi  (val_hi_hi),
    .ctl_out    (ctl_c[0]),
    .rem_out    (rem_c[0]),
    .num_out    (num_c[0]),
    .den_out    (den_c[0])
  );

  assign quo_c[0] = '0;

  // The magnitude is a weighted mean, so the quotient fits in VALUE_WIDTH bits and the
  // upper part of the numerator is already below the divisor. Each cell then settles
  // one quotient bit, most significant first.
  for (genvar i = 0; i < VW; i++) begin : g_cell
    abp_div_cell #(
      .VALUE_WIDTH   (VALUE_WIDTH),
      .SPACING_WIDTH (SPACING_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_c[i]),
      .rem_in  (rem_c[i]),
      .num_in  (num_c[i]),
      .quo_in  (quo_c[i]),
      .den_in  (den_c[i]),
      .ctl_out (ctl_c[i+1]),
      .rem_out (rem_c[i+1]),
      .num_out (num_c[i+1]),
      .quo_out (quo_c[i+1]),
      .den_out (den_c[i+1])
    );
  end

  // Restore the sign, truncating toward zero; an empty denominator gives zero.
  always_comb begin
    if (ctl_c[VW].den_zero) begin
      result_next = '0;
    end else if (ctl_c[VW].neg) begin
      result_next = ~quo_c[VW] + VW'(1);
    end else begin
      result_next = quo_c[VW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_c[VW].valid;
    end
    fine_value <= $signed(result_next);
  end

  // Every word taken comes out at the end of the pipeline, and nothing else does.
  a_latency_fwd : assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("word taken but no result after the pipeline latency");

  a_latency_bwd : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result strobe without a matching word");

  // The remainder left by the last cell stays below the divisor.
  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (ctl_c[VW].valid && !ctl_c[VW].den_zero) |-> (rem_c[VW] < den_c[VW]))
    else $error("division remainder not below divisor");

  a_zero_den : assert property (@(posedge clk) disable iff (rst)
    (ctl_c[VW].valid && ctl_c[VW].den_zero) |=> (done && fine_value == '0))
    else $error("empty denominator did not give zero");

  a_copy : assert property (@(posedge clk) disable iff (rst)
    (start && op == OP_COPY) |-> ##LAT (fine_value == $past(val_lo_lo, LAT)))
    else $error("copy class did not return the lower corner value");

endmodule

[sv/abp_front.sv]
// Front pipeline: weight selection, weighted products, their sum and the magnitude split.
module abp_front import abp_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int SPACING_WIDTH = SPACING_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     op,
  input  logic [SPACING_WIDTH-1:0]       rad_gap_lo,
  input  logic [SPACING_WIDTH-1:0]       rad_gap_hi,
  input  logic [SPACING_WIDTH-1:0]       ang_gap_lo,
  input  logic [SPACING_WIDTH-1:0]       ang_gap_hi,
  input  logic signed [VALUE_WIDTH-1:0]  val_lo_lo,
  input  logic signed [VALUE_WIDTH-1:0]  val_hi_lo,
  input  logic signed [VALUE_WIDTH-1:0]  val_lo_hi,
  input  logic signed [VALUE_WIDTH-1:0]  val_hi_hi,
  output ctl_t                           ctl_out,
  output logic [2*SPACING_WIDTH+1:0]     rem_out,
  output logic [VALUE_WIDTH-1:0]         num_out,
  output logic [2*SPACING_WIDTH+1:0]     den_out
);

  localparam int VW = VALUE_WIDTH;
  localparam int SW = SPACING_WIDTH;
  localparam int WW = 2 * SW;
  localparam int DW = 2 * SW + 2;
  localparam int PW = WW + VW + 1;
  localparam int TW = PW + 2;
  localparam int MW = DW + VW;

  logic [SW:0]           rad_sum;
  logic [SW:0]           ang_sum;
  logic [WW-1:0]         w_next [4];
  logic [SW:0]           d1_next;
  logic [SW:0]           d2_next;

  logic                  valid1, valid2, valid3, valid4;
  logic [WW-1:0]         w1 [4];
  logic signed [VW-1:0]  v1 [4];
  logic [SW:0]           d1_1, d2_1;
  logic signed [PW-1:0]  p2 [4];
  logic [DW-1:0]         den2, den3, den4;
  logic signed [PW:0]    sa3, sb3;
  logic signed [TW-1:0]  tot4;
  logic [TW-1:0]         tot_u;
  logic [TW-1:0]         mag_full;

  always_comb begin
    rad_sum = {1'b0, rad_gap_lo} + {1'b0, rad_gap_hi};
    ang_sum = {1'b0, ang_gap_lo} + {1'b0, ang_gap_hi};
    for (int i = 0; i < 4; i++) begin
      w_next[i] = '0;
    end
    d1_next = (SW+1)'(1);
    d2_next = (SW+1)'(1);
    case (op_t'(op))
      OP_COPY: begin
        w_next[0] = WW'(1);
      end
      OP_RADIAL: begin
        w_next[0] = WW'(rad_gap_lo);
        w_next[1] = WW'(rad_gap_hi);
        d1_next   = rad_sum;
      end
      OP_ANGULAR: begin
        w_next[0] = WW'(ang_gap_lo);
        w_next[2] = WW'(ang_gap_hi);
        d1_next   = ang_sum;
      end
      OP_CELL: begin
        w_next[0] = WW'(rad_gap_lo) * WW'(ang_gap_lo);
        w_next[1] = WW'(rad_gap_hi) * WW'(ang_gap_lo);
        w_next[2] = WW'(rad_gap_lo) * WW'(ang_gap_hi);
        w_next[3] = WW'(rad_gap_hi) * WW'(ang_gap_hi);
        d1_next   = rad_sum;
        d2_next   = ang_sum;
      end
      default: begin
        w_next[0] = '0;
      end
    endcase
  end

  assign tot_u    = tot4;
  assign mag_full = tot_u[TW-1] ? (~tot_u + TW'(1)) : tot_u;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1  <= 1'b0;
      valid2  <= 1'b0;
      valid3  <= 1'b0;
      valid4  <= 1'b0;
      ctl_out <= '0;
    end else begin
      valid1           <= start;
      valid2           <= valid1;
      valid3           <= valid2;
      valid4           <= valid3;
      ctl_out.valid    <= valid4;
      ctl_out.neg      <= tot_u[TW-1];
      ctl_out.den_zero <= (den4 == '0);
    end
    w1   <= w_next;
    v1[0] <= val_lo_lo;
    v1[1] <= val_hi_lo;
    v1[2] <= val_lo_hi;
    v1[3] <= val_hi_hi;
    d1_1 <= d1_next;
    d2_1 <= d2_next;
    for (int i = 0; i < 4; i++) begin
      p2[i] <= $signed({1'b0, w1[i]}) * v1[i];
    end
    den2    <= d1_1 * d2_1;
    sa3     <= (PW+1)'(p2[0]) + (PW+1)'(p2[1]);
    sb3     <= (PW+1)'(p2[2]) + (PW+1)'(p2[3]);
    den3    <= den2;
    tot4    <= TW'(sa3) + TW'(sb3);
    den4    <= den3;
    rem_out <= mag_full[MW-1:VW];
    num_out <= mag_full[VW-1:0];
    den_out <= den4;
  end

endmodule

[sv/abp_div_cell.sv]
// One restoring-division cell: settles one quotient bit and hands the word on.
module abp_div_cell import abp_pkg::*; #(
  parameter int VALUE_WIDTH   = VALUE_WIDTH_DEF,
  parameter int SPACING_WIDTH = SPACING_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctl_t                       ctl_in,
  input  logic [2*SPACING_WIDTH+1:0] rem_in,
  input  logic [VALUE_WIDTH-1:0]     num_in,
  input  logic [VALUE_WIDTH-1:0]     quo_in,
  input  logic [2*SPACING_WIDTH+1:0] den_in,
  output ctl_t                       ctl_out,
  output logic [2*SPACING_WIDTH+1:0] rem_out,
  output logic [VALUE_WIDTH-1:0]     num_out,
  output logic [VALUE_WIDTH-1:0]     quo_out,
  output logic [2*SPACING_WIDTH+1:0] den_out
);

  localparam int VW = VALUE_WIDTH;
  localparam int DW = 2 * SPACING_WIDTH + 2;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          q_bit;
  logic [DW-1:0] rem_next;

  // Bring down the next numerator bit and subtract the divisor if it fits.
  assign trial    = {rem_in, num_in[VW-1]};
  assign diff     = trial - {1'b0, den_in};
  assign q_bit    = ~diff[DW];
  assign rem_next = q_bit ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
    rem_out <= rem_next;
    num_out <= {num_in[VW-2:0], 1'b0};
    quo_out <= {quo_in[VW-2:0], q_bit};
    den_out <= den_in;
  end

endmodule
